[rtl/core/rbba_pkg.sv]
// ----------------------------------------------------------------------------
// rbba_pkg
// Shared types and constants of the region bounding-box and area accumulator.
// ----------------------------------------------------------------------------
package rbba_pkg;

    localparam int COORD_W = 10;
    localparam int LABEL_W = 8;
    localparam int AREA_W  = 21;

    // Frame limits; coordinates at or past them clamp to the last column/row.
    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;

    // Default table depth; labels at or past it bypass the table.
    localparam int MAX_LABELS_DEF = 256;
    // Labels that the label field can carry at all.
    localparam int LABEL_SPAN     = 1 << LABEL_W;

    // Pixel count stops here.
    localparam logic [AREA_W-1:0] AREA_SAT = AREA_W'(1048576);

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [AREA_W-1:0]  area_t;

    typedef struct packed {
        logic   first_of_frame;
        coord_t pixel_x;
        coord_t pixel_y;
        label_t region_label;
    } pixel_word_t;

    typedef struct packed {
        label_t label_out;
        coord_t box_xmin;
        coord_t box_xmax;
        coord_t box_ymin;
        coord_t box_ymax;
        coord_t centre_x;
        coord_t centre_y;
        area_t  pixel_area;
    } stats_word_t;

    // One table entry: bounding box and count of a label.
    typedef struct packed {
        coord_t xmin;
        coord_t xmax;
        coord_t ymin;
        coord_t ymax;
        area_t  area;
    } entry_t;

    // Lookup status of the pixel in the update stage.
    typedef struct packed {
        logic hit;       // label has a live entry this frame
        logic in_range;  // label maps into the table
    } lookup_t;

endpackage

[rtl/core/region_bbox_area_accumulator.sv]
// ----------------------------------------------------------------------------
// region_bbox_area_accumulator
// Per-label bounding box, centre and pixel count over a labelled pixel stream.
// ----------------------------------------------------------------------------
// Takes one labelled pixel word per clock while the stats side is ready and
// returns, for every pixel, one statistics word with that label's current box,
// centre and area; sustained rate is one pixel per clock while stats_ready is
// high. The two register stages are the read of the statistics RAM, registered
// with the pixel word on accept, and the update stage that writes the entry
// back and loads the output register driving stats_valid. Repeated labels on
// consecutive pixels are served from a forward register holding the entry
// written on the read edge. Per-label live bits sit in flip-flops: reset clears
// them at once, and a first-of-frame pixel clears all but its own label's bit
// together, so no clearing pass is needed. Labels at or above MAX_LABELS bypass
// the table and report the pixel alone with area 1. Backpressure on the stats
// side stalls the update stage, and input ready drops only while that stage is
// full and cannot drain.
// ----------------------------------------------------------------------------
module region_bbox_area_accumulator
    import rbba_pkg::*;
#(
    parameter int MAX_LABELS = MAX_LABELS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        pixel_valid,
    output logic        pixel_ready,
    input  pixel_word_t pixel,
    output logic        stats_valid,
    input  logic        stats_ready,
    output stats_word_t stats
);

    // Table depth: labels beyond the label field can never arrive.
    localparam int DEPTH = (MAX_LABELS < LABEL_SPAN) ? MAX_LABELS : LABEL_SPAN;
    localparam int AW    = $clog2(DEPTH);

    // Handshake
    logic accept;
    logic s1_adv;

    // Update stage
    logic          s1_valid_reg;
    pixel_word_t   s1_pix_reg;
    logic [AW-1:0] s1_addr;
    logic          s1_in_range;

    // Write-back forwarding
    logic          fwd_valid_reg;
    logic [AW-1:0] fwd_addr_reg;
    entry_t        fwd_entry_reg;

    // Live bits, one per label
    logic [DEPTH-1:0] live_reg;
    logic [DEPTH-1:0] live_next;

    // Datapath
    entry_t      ram_rd_data;
    entry_t      old_entry;
    entry_t      new_entry;
    lookup_t     lookup;
    stats_word_t upd_stats;
    logic        wr_en;

    // Output register
    logic        out_valid_reg;
    stats_word_t out_reg;

    assign s1_adv      = s1_valid_reg && (!out_valid_reg || stats_ready);
    assign pixel_ready = !s1_valid_reg || s1_adv;
    assign accept      = pixel_valid && pixel_ready;

    assign s1_addr     = s1_pix_reg.region_label[AW-1:0];
    assign s1_in_range = (32'(s1_pix_reg.region_label) < MAX_LABELS);

    // A frame start hides every old entry, this label's included.
    assign lookup.in_range = s1_in_range;
    assign lookup.hit      = s1_in_range && live_reg[s1_addr]
                             && !s1_pix_reg.first_of_frame;

    // RAM read on the accept edge misses a write made on that same edge.
    assign old_entry = (fwd_valid_reg && (fwd_addr_reg == s1_addr)) ? fwd_entry_reg
                                                                     : ram_rd_data;

    assign wr_en = s1_adv && s1_in_range;

    rbba_stat_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .rd_en   (accept),
        .rd_addr (pixel.region_label[AW-1:0]),
        .rd_data (ram_rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (new_entry)
    );

    rbba_update u_update (
        .pix       (s1_pix_reg),
        .old_entry (old_entry),
        .lookup    (lookup),
        .new_entry (new_entry),
        .stats     (upd_stats)
    );

    always_comb
    begin
        live_next = live_reg;
        if (s1_adv)
        begin
            if (s1_pix_reg.first_of_frame)
            begin
                live_next = '0;
            end
            if (s1_in_range)
            begin
                live_next[s1_addr] = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            fwd_valid_reg <= 1'b0;
            live_reg      <= '0;
        end
        else
        begin
            live_reg <= live_next;
            if (pixel_ready)
            begin
                s1_valid_reg  <= pixel_valid;
                // forward entry lives and dies with the word in the stage
                fwd_valid_reg <= pixel_valid && wr_en;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (stats_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg    <= pixel;
            fwd_addr_reg  <= s1_addr;
            fwd_entry_reg <= new_entry;
        end
        if (s1_adv)
        begin
            out_reg <= upd_stats;
        end
    end

    assign stats_valid = out_valid_reg;
    assign stats       = out_reg;

    // An in-table pixel leaves its label live.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_in_range) |=> live_reg[$past(s1_addr)])
        else $error("label not live after write-back");

    // A frame start leaves at most its own label live.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_adv && s1_pix_reg.first_of_frame) |=> ($countones(live_reg) <= 1))
        else $error("live bits survived frame start");

    // Every reported box is ordered and counts at least one pixel.
    assert property (@(posedge clk) disable iff (!rst_n)
        stats_valid |-> ((stats.box_xmin <= stats.box_xmax)
                         && (stats.box_ymin <= stats.box_ymax)
                         && (stats.pixel_area != '0)))
        else $error("malformed statistics word");

    // Forwarding only ever covers a word that is in the update stage.
    assert property (@(posedge clk) disable iff (!rst_n)
        fwd_valid_reg |-> s1_valid_reg)
        else $error("forward entry without a word in flight");

endmodule

[rtl/core/rbba_stat_ram.sv]
// ----------------------------------------------------------------------------
// rbba_stat_ram
// Per-label statistics memory: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module rbba_stat_ram
    import rbba_pkg::*;
#(
    parameter int DEPTH = MAX_LABELS_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output entry_t        rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  entry_t        wr_data
);

    entry_t mem [DEPTH];
    entry_t rd_data_reg;

    // Read returns the contents before a same-edge write.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/rbba_update.sv]
// ----------------------------------------------------------------------------
// rbba_update
// Merges one pixel into a label entry and forms the outgoing statistics word.
// ----------------------------------------------------------------------------
module rbba_update
    import rbba_pkg::*;
(
    input  pixel_word_t pix,
    input  entry_t      old_entry,
    input  lookup_t     lookup,
    output entry_t      new_entry,
    output stats_word_t stats
);

    coord_t px;
    coord_t py;
    entry_t fresh;
    entry_t merged;
    entry_t shown;
    coord_t span_x;
    coord_t span_y;

    // Clamp to frame.
    assign px = (32'(pix.pixel_x) >= MAX_WIDTH)  ? COORD_W'(MAX_WIDTH - 1)  : pix.pixel_x;
    assign py = (32'(pix.pixel_y) >= MAX_HEIGHT) ? COORD_W'(MAX_HEIGHT - 1) : pix.pixel_y;

    assign fresh = '{xmin: px, xmax: px, ymin: py, ymax: py, area: AREA_W'(1)};

    always_comb
    begin
        merged      = old_entry;
        merged.xmin = (px < old_entry.xmin) ? px : old_entry.xmin;
        merged.xmax = (px > old_entry.xmax) ? px : old_entry.xmax;
        merged.ymin = (py < old_entry.ymin) ? py : old_entry.ymin;
        merged.ymax = (py > old_entry.ymax) ? py : old_entry.ymax;
        merged.area = (old_entry.area < AREA_SAT) ? old_entry.area + AREA_W'(1)
                                                  : old_entry.area;
    end

    assign new_entry = lookup.hit ? merged : fresh;
    // Out-of-table labels report the lone pixel.
    assign shown     = lookup.in_range ? new_entry : fresh;

    assign span_x = shown.xmax - shown.xmin;
    assign span_y = shown.ymax - shown.ymin;

    assign stats.label_out  = pix.region_label;
    assign stats.box_xmin   = shown.xmin;
    assign stats.box_xmax   = shown.xmax;
    assign stats.box_ymin   = shown.ymin;
    assign stats.box_ymax   = shown.ymax;
    assign stats.centre_x   = shown.xmin + (span_x >> 1);
    assign stats.centre_y   = shown.ymin + (span_y >> 1);
    assign stats.pixel_area = shown.area;

endmodule
